// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Word type, request action codes, round constants, initial hash values and
// the round and schedule mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned HASH_WORDS  = 8;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t sha_iv(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h6a09e667;
    endcase
    sha_iv = r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
      default: r = 32'h428a2f98;
    endcase
    round_k = r;
  endfunction

endpackage

// ===== src/sha256_byte_stream_hasher.sv =====
// Absorb: the request that fills a block starts a compression, in order hash reads,
//   a schedule prefetch, the rounds and the hash write-backs.
// Finish: the padding words are written, one or two compressions run, then each digest
//   word is read from the hash memory and held back while the output stalls.
// Throughput: one byte per cycle between blocks; no byte is taken while a block compresses.
// Reset: control clears; hash memory reads as initial values via a flag until written.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Byte-wide absorb into a 16-word block memory, one round per cycle
// compression against an 8-word chaining hash memory, digest read out word
// by word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha256_pkg::word_t    out_digest_word,
  output logic [2:0]           out_word_index,
  output logic                 out_last_word
);
  import sha256_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PAD0  = 4'd1;
  localparam logic [3:0] S_PADZ  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_PRE   = 4'd4;
  localparam logic [3:0] S_ROUND = 4'd5;
  localparam logic [3:0] S_FINAL = 4'd6;
  localparam logic [3:0] S_OREAD = 4'd7;
  localparam logic [3:0] S_OLOAD = 4'd8;

  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_PAD  = 2'd1;
  localparam logic [1:0] RET_OUT  = 2'd2;

  // control
  logic [3:0]  state_r, state_nxt;
  logic [1:0]  ret_r, ret_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] count_r, count_nxt;
  logic [3:0]  pad_idx_r, pad_idx_nxt;
  logic        extra_r, extra_nxt;
  logic        hash_iv_r, hash_iv_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath
  logic [23:0] asm_r;
  word_t       v_r [HASH_WORDS];
  word_t       w_r [BLOCK_WORDS];
  word_t       wk_r;
  word_t       out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  // memories
  word_t       buf_mem  [BLOCK_WORDS];
  word_t       hash_mem [HASH_WORDS];
  word_t       buf_rd_r, hash_rd_r;
  logic        buf_we, hash_we;
  logic [3:0]  buf_waddr, buf_raddr;
  logic [2:0]  hash_waddr, hash_raddr;
  word_t       buf_wdata, hash_wdata;

  logic        in_acc, out_acc, absorb_acc, finish_acc;
  logic        out_load;
  word_t       pad_word, sched_w, next_w;
  word_t       t1, t2;
  logic [63:0] bit_len;
  logic [5:0]  cnt_m1;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid & in_ready;
  assign absorb_acc = in_acc & (in_action == ACT_ABSORB);
  assign finish_acc = in_acc & (in_action != ACT_ABSORB);
  assign out_acc    = out_valid_r & out_ready;
  assign out_load   = (state_r == S_OLOAD) & (~out_valid_r | out_ready);

  assign bit_len = {count_r, 3'b000};
  assign cnt_m1  = cnt_r - 6'd1;

  // partial word closed with the pad marker
  always_comb begin
    unique case (fill_r[1:0])
      2'd0: pad_word = {PAD_BYTE, 24'h0};
      2'd1: pad_word = {asm_r[7:0], PAD_BYTE, 16'h0};
      2'd2: pad_word = {asm_r[15:0], PAD_BYTE, 8'h0};
      2'd3: pad_word = {asm_r[23:0], PAD_BYTE};
      default: pad_word = {PAD_BYTE, 24'h0};
    endcase
  end

  // schedule for word t+1: window holds W[t-15..t]
  assign sched_w = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
  assign next_w  = (cnt_r < 6'd15) ? buf_rd_r : sched_w;

  assign t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + wk_r;
  assign t2 = big_sigma0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // memory ports
  always_comb begin
    buf_we     = 1'b0;
    buf_waddr  = fill_r[5:2];
    buf_wdata  = {asm_r, in_data_byte};
    buf_raddr  = 4'd0;
    hash_we    = 1'b0;
    hash_waddr = cnt_m1[2:0];
    hash_wdata = hash_rd_r + v_r[0];
    hash_raddr = cnt_r[2:0];
    unique case (state_r)
      S_IDLE: begin
        buf_we = absorb_acc & (fill_r[1:0] == 2'd3);
      end
      S_PAD0: begin
        buf_we    = 1'b1;
        buf_wdata = pad_word;
      end
      S_PADZ: begin
        buf_we    = 1'b1;
        buf_waddr = pad_idx_r;
        if (!extra_r && pad_idx_r == 4'd14) begin
          buf_wdata = bit_len[63:32];
        end else if (!extra_r && pad_idx_r == 4'd15) begin
          buf_wdata = bit_len[31:0];
        end else begin
          buf_wdata = '0;
        end
      end
      S_LOAD:  buf_raddr = 4'd0;
      S_PRE:   buf_raddr = 4'd1;
      S_ROUND: buf_raddr = cnt_r[3:0] + 4'd2;
      S_FINAL: hash_we = (cnt_r != 6'd0);
      S_OREAD: hash_raddr = oidx_r;
      S_OLOAD: hash_raddr = oidx_r;
      default: buf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_rd_r <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[hash_waddr] <= hash_wdata;
    end
    hash_rd_r <= hash_iv_r ? sha_iv(hash_raddr) : hash_mem[hash_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    pad_idx_nxt   = pad_idx_r;
    extra_nxt     = extra_r;
    hash_iv_nxt   = hash_iv_r;
    oidx_nxt      = oidx_r;
    out_valid_nxt = out_valid_r & ~out_acc;
    unique case (state_r)
      S_IDLE: begin
        if (absorb_acc) begin
          fill_nxt  = fill_r + 6'd1;
          count_nxt = count_r + 61'd1;
          if (fill_r == 6'd63) begin
            state_nxt = S_LOAD;
            ret_nxt   = RET_IDLE;
            cnt_nxt   = '0;
          end
        end else if (finish_acc) begin
          state_nxt = S_PAD0;
        end
      end
      S_PAD0: begin
        if (fill_r[5:2] == 4'd15) begin
          // marker in the last word: the length goes into a second block
          state_nxt   = S_LOAD;
          ret_nxt     = RET_PAD;
          cnt_nxt     = '0;
          extra_nxt   = 1'b0;
          pad_idx_nxt = '0;
        end else begin
          state_nxt   = S_PADZ;
          extra_nxt   = (fill_r[5:3] == 3'd7);
          pad_idx_nxt = fill_r[5:2] + 4'd1;
        end
      end
      S_PADZ: begin
        pad_idx_nxt = pad_idx_r + 4'd1;
        if (pad_idx_r == 4'd15) begin
          state_nxt = S_LOAD;
          cnt_nxt   = '0;
          extra_nxt = 1'b0;
          ret_nxt   = extra_r ? RET_PAD : RET_OUT;
        end
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          state_nxt = S_PRE;
          cnt_nxt   = '0;
        end
      end
      S_PRE: begin
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = S_FINAL;
          cnt_nxt   = '0;
        end
      end
      S_FINAL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          hash_iv_nxt = 1'b0;
          cnt_nxt     = '0;
          oidx_nxt    = '0;
          unique case (ret_r)
            RET_PAD: state_nxt = S_PADZ;
            RET_OUT: state_nxt = S_OREAD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_OREAD: begin
        state_nxt = S_OLOAD;
      end
      S_OLOAD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          oidx_nxt      = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            // message done: fresh chaining value for the next one
            state_nxt   = S_IDLE;
            hash_iv_nxt = 1'b1;
            fill_nxt    = '0;
            count_nxt   = '0;
          end else begin
            state_nxt = S_OREAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      pad_idx_r   <= '0;
      extra_r     <= 1'b0;
      hash_iv_r   <= 1'b1;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      pad_idx_r   <= pad_idx_nxt;
      extra_r     <= extra_nxt;
      hash_iv_r   <= hash_iv_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (absorb_acc) begin
      asm_r <= {asm_r[15:0], in_data_byte};
    end
    unique case (state_r)
      S_LOAD: begin
        if (cnt_r != 6'd0) begin
          for (int i = 0; i < HASH_WORDS - 1; i++) begin
            v_r[i] <= v_r[i+1];
          end
          v_r[HASH_WORDS-1] <= hash_rd_r;
        end
      end
      S_PRE: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[BLOCK_WORDS-1] <= buf_rd_r;
        wk_r <= buf_rd_r + round_k(6'd0);
      end
      S_ROUND: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[BLOCK_WORDS-1] <= next_w;
        wk_r   <= next_w + round_k(cnt_r + 6'd1);
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      S_FINAL: begin
        if (cnt_r != 6'd0) begin
          for (int i = 0; i < HASH_WORDS - 1; i++) begin
            v_r[i] <= v_r[i+1];
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_word_r <= hash_rd_r;
      out_idx_r  <= oidx_r;
      out_last_r <= (oidx_r == 3'd7);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds byte messages and finish requests through the valid/ready input,
// predicts each eight-word digest with a behavioural SHA-256 model or a known
// digest, and checks every digest word on the output channel. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  localparam int unsigned TARGET_ITEMS = 410;
  localparam int unsigned DRAIN_CYCLES = 200;

  localparam word_t ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // well-known digests, word 0 in the top bits
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  typedef struct packed {
    logic         action;
    logic [7:0]   data_byte;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  localparam int unsigned DIRECTED_COUNT = 17;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{ACT_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},   // empty message straight after reset
    '{ACT_ABSORB, 8'h61, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h62, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h63, 1'b0, 256'h0},
    '{ACT_FINISH, 8'h00, 1'b1, ABC_DIGEST},
    '{ACT_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},   // back-to-back finish, byte ignored
    '{ACT_ABSORB, 8'h00, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'hff, 1'b0, 256'h0},
    '{ACT_FINISH, 8'h00, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'hff, 1'b0, 256'h0},
    '{ACT_FINISH, 8'h00, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h80, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h7f, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h55, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'haa, 1'b0, 256'h0},
    '{ACT_FINISH, 8'h5a, 1'b0, 256'h0},
    '{ACT_FINISH, 8'ha5, 1'b1, EMPTY_DIGEST}
  };

  localparam int unsigned EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef struct packed {
    word_t      word;
    logic [2:0] pos;
    logic       last;
  } digest_out_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic       in_action    = ACT_ABSORB;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  word_t      out_digest_word;
  logic [2:0] out_word_index;
  logic       out_last_word;

  sha256_byte_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural hash state
  word_t       running_hash [8];
  logic [7:0]  pending_block [64];
  logic [5:0]  pending_fill;
  logic [60:0] message_bytes;
  word_t       model_digest [8];

  digest_out_t digest_words_due [$];
  digest_out_t due_word;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_mode     = 0;
  int unsigned stall_window   = 0;

  function automatic word_t rot_right(input word_t x, input int unsigned n);
    logic [63:0] doubled;
    doubled = {x, x} >> n;
    return doubled[31:0];
  endfunction

  task automatic compress_pending();
    word_t sched [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {pending_block[4*i], pending_block[4*i+1],
                  pending_block[4*i+2], pending_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (int i = 0; i < 8; i++)
      v[i] = running_hash[i];
    for (int i = 0; i < 64; i++) begin
      s1 = rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
      s0 = rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      running_hash[i] = running_hash[i] + v[i];
  endtask

  task automatic hash_restart();
    for (int i = 0; i < 8; i++)
      running_hash[i] = START_HASH[i];
    pending_fill  = '0;
    message_bytes = '0;
  endtask

  // advances the hash state by one request; digest lands in model_digest
  task automatic hash_model_step(input logic act, input logic [7:0] b, output bit produced);
    logic [63:0] bit_len;
    int unsigned pos;
    produced = 1'b0;
    if (act == ACT_ABSORB) begin
      pending_block[pending_fill] = b;
      pending_fill  = pending_fill + 6'd1;
      message_bytes = message_bytes + 61'd1;
      if (pending_fill == 6'd0)
        compress_pending();
    end else begin
      bit_len = {message_bytes, 3'b000};
      pos = pending_fill;
      pending_block[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          pending_block[pos] = 8'h00;
          pos++;
        end
        compress_pending();
        pos = 0;
      end
      while (pos < 56) begin
        pending_block[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++)
        pending_block[63-i] = bit_len[8*i +: 8];
      compress_pending();
      for (int i = 0; i < 8; i++)
        model_digest[i] = running_hash[i];
      hash_restart();
      produced = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // drives one request in bursts, then books the digest it causes
  task automatic send_request(input logic act, input logic [7:0] b, input logic known,
                              input logic [255:0] typed);
    int unsigned gap;
    bit produced;
    word_t w;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    hash_model_step(act, b, produced);
    if (produced) begin
      for (int i = 0; i < 8; i++) begin
        w = known ? typed[255 - 32*i -: 32] : model_digest[i];
        digest_words_due.push_back('{word: w, pos: 3'(i), last: (i == 7)});
      end
    end
  endtask

  // receiver stall pattern: the mode changes when a random window runs out
  always @(posedge clk) begin
    if (stall_window == 0) begin
      stall_mode   = $urandom_range(0, 3);
      stall_window = $urandom_range(16, 96);
    end
    stall_window--;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= $urandom_range(0, 1);
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= (stall_window % 11 == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_words_due.size() == 0) begin
        report_mismatch("digest word with nothing due", 32'h0, out_digest_word);
      end else begin
        due_word = digest_words_due.pop_front();
        if (out_digest_word !== due_word.word)
          report_mismatch($sformatf("digest word %0d", due_word.pos), due_word.word,
                          out_digest_word);
        if (out_word_index !== due_word.pos)
          report_mismatch("word index", 32'(due_word.pos), 32'(out_word_index));
        if (out_last_word !== due_word.last)
          report_mismatch($sformatf("last marker on word %0d", due_word.pos),
                          32'(due_word.last), 32'(out_last_word));
      end
    end
  end

  initial begin
    int unsigned msg_len;
    for (int i = 0; i < 64; i++)
      pending_block[i] = 8'h00;
    hash_restart();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_COUNT; r++)
      send_request(DIRECTED_ROWS[r].action, DIRECTED_ROWS[r].data_byte,
                   DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].digest);

    // whole messages with random content; lengths lean on the padding boundaries
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: msg_len = $urandom_range(0, 8);
        4, 5, 6, 7: msg_len = EDGE_LENGTHS[$urandom_range(0, 9)];
        default:    msg_len = $urandom_range(0, 140);
      endcase
      // last message trimmed so the run stays near the target
      if (msg_len + 1 > TARGET_ITEMS - items_sent)
        msg_len = TARGET_ITEMS - items_sent - 1;
      repeat (msg_len)
        send_request(ACT_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
      send_request(ACT_FINISH, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
    end
    in_valid <= 1'b0;

    while (digest_words_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TIMEOUT: %0d digest words still due", digest_words_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
